FILE: src/b64e_pkg.sv
// Package for the Base64 stream encoder: payload types, job record, alphabet lookup.
package b64e_pkg;

    localparam int LINE_CHARS_DEF  = 76;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_FULL = 2'd0,
        JOB_PAD1 = 2'd1,
        JOB_PAD2 = 2'd2
    } job_kind_t;

    // One unit of output work: a full group or a padded tail.
    typedef struct packed {
        job_kind_t   kind;
        logic        crlf;
        logic        last;
        logic [23:0] word;
    } job_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] v8;
        logic [7:0] c;
        v8 = {2'b00, v};
        if (v < 6'd26)
            c = 8'h41 + v8;
        else if (v < 6'd52)
            c = 8'h61 + (v8 - 8'd26);
        else if (v < 6'd62)
            c = 8'h30 + (v8 - 8'd52);
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

FILE: src/b64e_front.sv
// Front end: accepts bytes, tracks group phase and line count, issues jobs.
module b64e_front #(
    parameter int LINE_CHARS = b64e_pkg::LINE_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               accept,
    input  b64e_pkg::in_item_t item,
    output logic               push,
    output b64e_pkg::job_t     job
);

    localparam int CNT_W = $clog2(LINE_CHARS + 4);

    logic             wrap_en_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [CNT_W-1:0] line_cnt_reg, line_cnt_next;
    logic [CNT_W-1:0] cnt_sum;
    logic             line_full;

    assign cnt_sum   = line_cnt_reg + CNT_W'(4);
    assign line_full = (cnt_sum >= CNT_W'(LINE_CHARS));

    always_comb
    begin
        phase_next    = phase_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        line_cnt_next = line_cnt_reg;
        push          = 1'b0;
        job.kind      = b64e_pkg::JOB_FULL;
        job.crlf      = 1'b0;
        job.last      = item.end_of_message;
        job.word      = {held0_reg, held1_reg, item.data_byte};
        if (accept)
        begin
            if (phase_reg[1])
            begin
                // third byte closes a group
                push          = 1'b1;
                job.crlf      = line_full & wrap_en_reg;
                phase_next    = 2'd0;
                line_cnt_next = line_full ? '0 : cnt_sum;
            end
            else
            begin
                if (phase_reg[0])
                    held1_next = item.data_byte;
                else
                    held0_next = item.data_byte;
                phase_next = phase_reg + 2'd1;
                if (item.end_of_message)
                begin
                    push = 1'b1;
                    if (phase_reg[0])
                    begin
                        job.kind = b64e_pkg::JOB_PAD2;
                        job.word = {held0_reg, item.data_byte, 8'h00};
                    end
                    else
                    begin
                        job.kind = b64e_pkg::JOB_PAD1;
                        job.word = {item.data_byte, 16'h0000};
                    end
                end
            end
            if (item.end_of_message)
            begin
                phase_next    = 2'd0;
                line_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_en_reg  <= 1'b0;
            phase_reg    <= 2'd0;
            line_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                wrap_en_reg <= cfg_wr_data;
            phase_reg    <= phase_next;
            line_cnt_reg <= line_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

    phase_range_a: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("group phase out of range");

    line_cnt_a: assert property (@(posedge clk) disable iff (!rst_n)
        line_cnt_reg < CNT_W'(LINE_CHARS))
        else $error("line count reached line length without wrapping");

endmodule

FILE: src/b64e_queue.sv
// Short job queue between the front end and the character emitter.
module b64e_queue #(
    parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::job_t push_job,
    output logic           push_ready,
    input  logic           pop,
    output logic           head_valid,
    output b64e_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64e_pkg::job_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entries[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    no_overflow_a: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_ready)
        else $error("job pushed into full queue");

    no_underflow_a: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job popped from empty queue");

endmodule

FILE: src/b64e_back.sv
// Back end: walks the head job into out_reg, one char per cycle unless stalled.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  b64e_pkg::job_t      head_job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output b64e_pkg::out_item_t out_item
);

    logic [2:0]          idx_reg;
    logic                out_valid_reg;
    b64e_pkg::out_item_t out_reg;
    logic                load;
    logic [2:0]          final_idx;
    logic                at_final;
    logic [5:0]          sextet;
    logic [7:0]          ch;

    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign final_idx = (head_job.kind == b64e_pkg::JOB_FULL && head_job.crlf) ? 3'd5 : 3'd3;
    assign at_final  = (idx_reg == final_idx);
    assign pop       = load && at_final;

    always_comb
    begin
        unique case (idx_reg[1:0])
            2'd0:    sextet = head_job.word[23:18];
            2'd1:    sextet = head_job.word[17:12];
            2'd2:    sextet = head_job.word[11:6];
            default: sextet = head_job.word[5:0];
        endcase
        if (idx_reg == 3'd4)
            ch = b64e_pkg::CHAR_CR;
        else if (idx_reg == 3'd5)
            ch = b64e_pkg::CHAR_LF;
        else if (head_job.kind == b64e_pkg::JOB_PAD1 && idx_reg >= 3'd2)
            ch = b64e_pkg::CHAR_PAD;
        else if (head_job.kind == b64e_pkg::JOB_PAD2 && idx_reg == 3'd3)
            ch = b64e_pkg::CHAR_PAD;
        else
            ch = b64e_pkg::b64_char(sextet);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= at_final ? 3'd0 : idx_reg + 3'd1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.out_char  <= ch;
            out_reg.last_char <= head_job.last && at_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    mid_job_a: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> head_valid)
        else $error("job left the queue before all characters were sent");

endmodule

FILE: src/base64_stream_encoder.sv
// Flow: a byte that closes a group or ends a message pushes one job into the queue;
// its characters then leave in order through the output register.
// Throughput: one byte per cycle while the four-job queue has room; the emitter sends
// one character per cycle while char_ready takes them.
// Reset (rst_n, async low) empties the queue and output stage, clears phase, line
// count and disables line wrapping.
module base64_stream_encoder #(
    parameter int LINE_CHARS  = b64e_pkg::LINE_CHARS_DEF,
    parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  b64e_pkg::in_item_t  byte_data,
    output logic                char_valid,
    input  logic                char_ready,
    output b64e_pkg::out_item_t char_data
);

    logic           push;
    logic           push_ready;
    b64e_pkg::job_t push_job;
    logic           pop;
    logic           head_valid;
    b64e_pkg::job_t head_job;
    logic           accept;

    assign byte_ready = push_ready;
    assign accept     = byte_valid && push_ready;

    b64e_front #(
        .LINE_CHARS (LINE_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (byte_data),
        .push        (push),
        .job         (push_job)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    b64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (char_valid),
        .out_ready  (char_ready),
        .out_item   (char_data)
    );

endmodule

FILE: dv/tb_base64_stream_encoder.sv
// Testbench for base64_stream_encoder: directed and random byte streams checked against a character predictor.
`timescale 1ns / 1ps

module tb_base64_stream_encoder;

    // Tracks encoder state per accepted byte and holds the characters still owed.
    class encode_checker;
        string                alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        b64e_pkg::out_item_t  pending_chars[$];
        int                   errors = 0;
        logic [7:0]           held [2] = '{8'h00, 8'h00};
        logic [1:0]           phase = 2'd0;
        logic [6:0]           line_cnt = 7'd0;
        logic                 wrap = 1'b0;

        function void push_char(logic [7:0] c);
            b64e_pkg::out_item_t e;
            e.out_char  = c;
            e.last_char = 1'b0;
            pending_chars.push_back(e);
        endfunction

        function void push_sym(logic [5:0] v);
            push_char(alphabet[v]);
        endfunction

        function void take_byte(b64e_pkg::in_item_t it);
            int                  start_size;
            b64e_pkg::out_item_t tail;
            start_size = pending_chars.size();
            if (phase >= 2'd2)
            begin
                push_sym(held[0][7:2]);
                push_sym({held[0][1:0], held[1][7:4]});
                push_sym({held[1][3:0], it.data_byte[7:6]});
                push_sym(it.data_byte[5:0]);
                phase = 2'd0;
                // line count runs even with wrapping off
                line_cnt = line_cnt + 7'd4;
                if (line_cnt >= b64e_pkg::LINE_CHARS_DEF)
                begin
                    line_cnt = 7'd0;
                    if (wrap)
                    begin
                        push_char(b64e_pkg::CHAR_CR);
                        push_char(b64e_pkg::CHAR_LF);
                    end
                end
            end
            else
            begin
                held[phase[0]] = it.data_byte;
                phase = phase + 2'd1;
            end
            if (it.end_of_message)
            begin
                if (phase == 2'd1)
                begin
                    push_sym(held[0][7:2]);
                    push_sym({held[0][1:0], 4'h0});
                    push_char(b64e_pkg::CHAR_PAD);
                    push_char(b64e_pkg::CHAR_PAD);
                end
                else if (phase == 2'd2)
                begin
                    push_sym(held[0][7:2]);
                    push_sym({held[0][1:0], held[1][7:4]});
                    push_sym({held[1][3:0], 2'b00});
                    push_char(b64e_pkg::CHAR_PAD);
                end
                if (pending_chars.size() > start_size)
                begin
                    tail = pending_chars.pop_back();
                    tail.last_char = 1'b1;
                    pending_chars.push_back(tail);
                end
                held[0]  = 8'h00;
                held[1]  = 8'h00;
                phase    = 2'd0;
                line_cnt = 7'd0;
            end
        endfunction

        function void match_char(b64e_pkg::out_item_t got);
            b64e_pkg::out_item_t want;
            if (pending_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected char %h last %b", $time, got.out_char, got.last_char);
                return;
            end
            want = pending_chars.pop_front();
            if (got.out_char !== want.out_char)
            begin
                errors++;
                $display("%0t: out_char expected %h actual %h", $time, want.out_char,
                         got.out_char);
            end
            if (got.last_char !== want.last_char)
            begin
                errors++;
                $display("%0t: last_char expected %b actual %b", $time, want.last_char,
                         got.last_char);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic                cfg_wr_data;
    logic                byte_valid;
    logic                byte_ready;
    b64e_pkg::in_item_t  byte_data;
    logic                char_valid;
    logic                char_ready;
    b64e_pkg::out_item_t char_data;

    encode_checker chk = new();
    int            hold_left = 0;

    base64_stream_encoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_data   (char_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, a few long ones, and now and then a run with none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Message lengths: many short, some medium, some around one full line, a few around two lines.
    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 8);
        if (r < 75)
            return $urandom_range(9, 30);
        if (r < 90)
            return $urandom_range(55, 60);
        return $urandom_range(100, 130);
    endfunction

    task automatic send_byte(logic [7:0] b, logic eom, int gap);
        b64e_pkg::in_item_t it;
        it.data_byte      = b;
        it.end_of_message = eom;
        repeat (gap)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_data  <= it;
        do
            @(posedge clk);
        while (!byte_ready);
        chk.take_byte(it);
    endtask

    task automatic drain_chars();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (chk.pending_chars.size() != 0)
            @(posedge clk);
        // bytes that only fill a group produce nothing; let them settle
        repeat (10) @(posedge clk);
    endtask

    task automatic write_wrap(logic v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        chk.wrap = v;
    endtask

    // Sender
    initial
    begin
        logic [7:0] dir_bytes [$];
        int         dir_lens [$];
        logic       wrap_plan [$];
        int         idx;
        int         remaining;
        int         calm;

        dir_bytes = '{8'h00,
                      8'hFF,
                      8'h00, 8'hFF,
                      8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h00, 8'h00, 8'h80,
                      8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD,
                      8'h4D, 8'h61, 8'h6E, 8'h01, 8'h02, 8'h03};
        dir_lens  = '{1, 1, 2, 3, 4, 5, 6};
        wrap_plan = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        idx       = 0;
        remaining = 0;
        calm      = 0;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        byte_valid  = 1'b0;
        byte_data   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every leftover size, wrapping at its reset value
        foreach (dir_lens[m])
        begin
            for (int k = 0; k < dir_lens[m]; k++)
            begin
                send_byte(dir_bytes[idx], k == dir_lens[m] - 1, pick_gap(calm));
                idx++;
            end
        end

        // random: a message may run across a register change
        foreach (wrap_plan[p])
        begin
            drain_chars();
            write_wrap(wrap_plan[p]);
            for (int n = 0; n < 80; n++)
            begin
                if (remaining == 0)
                    remaining = pick_msg_len();
                send_byte(8'($urandom_range(0, 255)), remaining == 1, pick_gap(calm));
                remaining--;
            end
        end
        while (remaining > 0)
        begin
            send_byte(8'($urandom_range(0, 255)), remaining == 1, pick_gap(calm));
            remaining--;
        end

        drain_chars();
        if (chk.errors == 0 && chk.pending_chars.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver
    initial
    begin
        int stall;
        int calm;
        int seen;

        stall      = 0;
        calm       = 0;
        seen       = 0;
        char_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                char_ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                char_ready <= 1'b0;
            end
            else
                char_ready <= 1'b1;
            @(posedge clk);
            if (char_valid && char_ready)
            begin
                chk.match_char(char_data);
                seen++;
                // one long back-pressure window so the job queue fills and input stalls
                if (seen == 60)
                    hold_left = 400;
                stall = pick_gap(calm);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
